>>> rtl/kblb_pkg.sv
// ----------------------------------------------------------------------------
// kblb_pkg
// Shared types and constants of the keyboard line buffer with echo.
// ----------------------------------------------------------------------------
package kblb_pkg;

  // Default number of bytes the line buffer holds
  localparam int unsigned DEFAULT_DEPTH = 64;

  // Key codes with a meaning of their own
  localparam logic [7:0] KEY_TAB       = 8'd9;
  localparam logic [7:0] KEY_ENTER     = 8'd13;
  localparam logic [7:0] KEY_SPACE     = 8'd32;
  localparam logic [7:0] KEY_TILDE     = 8'd126;
  localparam logic [7:0] KEY_BACKSPACE = 8'd127;

  // Display codes used by the echo
  localparam logic [7:0] ECHO_BS     = 8'd8;
  localparam logic [7:0] ECHO_NL     = 8'd10;
  localparam logic [7:0] ECHO_CARET  = 8'd94;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;

  // Action codes
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Fill level field width on the result
  localparam int unsigned FILL_W = 7;

  typedef struct packed {
    logic       action;
    logic [7:0] key_byte;
  } kblb_in_t;

  typedef struct packed {
    logic [7:0]        echo_byte;
    logic              echo_valid;
    logic [7:0]        read_byte;
    logic              line_done;
    logic [FILL_W-1:0] fill_level;
    logic              last;
  } kblb_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } kblb_state_e;

endpackage

>>> rtl/kblb_ram.sv
// ----------------------------------------------------------------------------
// kblb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module kblb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held when no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/kblb_echo.sv
// ----------------------------------------------------------------------------
// kblb_echo
// Echo formatter: length of the echo sequence of a key and its display
// byte at a given position.
// ----------------------------------------------------------------------------
module kblb_echo (
  input  logic [7:0] key_i,
  input  logic [1:0] idx_i,
  input  logic       enable_i,
  input  logic       full_i,
  output logic [1:0] len_o,
  output logic [7:0] char_o
);
  import kblb_pkg::*;

  logic is_plain;

  assign is_plain = (key_i == KEY_TAB) || (key_i inside {[KEY_SPACE:KEY_TILDE]});

  // Classify the key into its echo form
  always_comb begin
    len_o  = 2'd2;
    char_o = (idx_i == 2'd0) ? ECHO_CARET : key_i + CTRL_OFFSET;
    if (is_plain) begin
      len_o  = 2'd1;
      char_o = key_i;
    end else if (key_i == KEY_ENTER) begin
      len_o  = 2'd1;
      char_o = ECHO_NL;
    end else if (key_i == KEY_BACKSPACE) begin
      len_o  = 2'd3;
      char_o = (idx_i == 2'd1) ? KEY_SPACE : ECHO_BS;
    end
    // Drop the echo when it is switched off or the buffer was full
    if (full_i || !enable_i) begin
      len_o = 2'd0;
    end
  end

endmodule

>>> rtl/keyboard_line_buffer_with_echo_core.sv
// ----------------------------------------------------------------------------
// keyboard_line_buffer_with_echo_core
// Console input line buffer with echo, built around one byte RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_i and raise start; the transaction is taken at
//   a clock edge with start high and busy low. busy stays high until the
//   last result of that transaction has been shown.
//   Results: res_o is valid for exactly one cycle when res_strobe_o is high;
//   res_o.last marks the final result of a transaction. The receiver must
//   take every strobed result; there is no back-pressure.
//   Configuration: cfg_echo_enable_i is written when cfg_valid_i is high;
//   cfg_ready_o is always high. Write it only while busy is low.
// Transactions:
//   A read transaction issues the RAM read at the accept edge if the buffer
//   is not empty and shows its result in the next cycle. A key transaction
//   writes the RAM at the accept edge unless it is a backspace or the buffer
//   is full, and then shows one result per echo byte (one when there is no
//   echo), at most three. The echo sequencer emits one byte per cycle.
// Reset:
//   The buffer becomes empty and echo is enabled. RAM content is not
//   cleared; only written entries are ever read back.
// ----------------------------------------------------------------------------
module keyboard_line_buffer_with_echo_core #(
  parameter int unsigned BUFFER_DEPTH = kblb_pkg::DEFAULT_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  kblb_pkg::kblb_in_t  in_i,
  output logic              res_strobe_o,
  output kblb_pkg::kblb_out_t res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_echo_enable_i
);
  import kblb_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  kblb_state_e   state_q, state_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] held_q, held_d;
  logic [7:0]    key_q, key_d;
  logic [1:0]    idx_q, idx_d;
  logic          done_q, done_d;
  logic          hit_q, hit_d;
  logic          wfull_q, wfull_d;
  logic          echo_en_q, echo_en_d;

  logic          accept;
  logic          full;
  logic          empty;
  logic          last_res;
  logic          ram_we;
  logic          ram_re;
  logic [AW:0]   wsum;
  logic [AW-1:0] waddr;
  logic [AW-1:0] oldest_inc;
  logic [7:0]    rdata;
  logic [1:0]    echo_len;
  logic [7:0]    echo_char;
  logic [CW+FILL_W-1:0] fill_ext;

  assign accept      = start && (state_q == ST_IDLE);
  assign full        = (held_q == CW'(BUFFER_DEPTH));
  assign empty       = (held_q == '0);
  assign cfg_ready_o = 1'b1;

  // Newest slot: oldest + held stays below twice the depth
  assign wsum  = (AW+1)'(oldest_q) + (AW+1)'(held_q);
  assign waddr = (wsum >= (AW+1)'(BUFFER_DEPTH)) ?
                 AW'(wsum - (AW+1)'(BUFFER_DEPTH)) : wsum[AW-1:0];

  // Wrap the oldest pointer at the depth
  assign oldest_inc = (oldest_q == AW'(BUFFER_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

  // Byte store; a write and a later read of the same slot never overlap
  // since each transaction finishes its RAM access at its accept edge
  kblb_ram #(
    .Width (8),
    .Depth (BUFFER_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (in_i.key_byte),
    .re_i    (ram_re),
    .raddr_i (oldest_q),
    .rdata_o (rdata)
  );

  // Echo formatter on the held key
  kblb_echo u_echo (
    .key_i    (key_q),
    .idx_i    (idx_q),
    .enable_i (echo_en_q),
    .full_i   (wfull_q),
    .len_o    (echo_len),
    .char_o   (echo_char)
  );

  assign last_res = (echo_len == 2'd0) || (idx_q == echo_len - 2'd1);

  // Update pointers, count and the held transaction
  always_comb begin
    oldest_d  = oldest_q;
    held_d    = held_q;
    key_d     = key_q;
    idx_d     = idx_q;
    done_d    = done_q;
    hit_d     = hit_q;
    wfull_d   = wfull_q;
    echo_en_d = cfg_valid_i ? cfg_echo_enable_i : echo_en_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    if (state_q == ST_EMIT) begin
      idx_d = idx_q + 2'd1;
    end
    if (accept) begin
      if (in_i.action == ACT_READ) begin
        hit_d = !empty;
        if (!empty) begin
          ram_re   = 1'b1;
          oldest_d = oldest_inc;
          held_d   = held_q - 1'b1;
        end
      end else begin
        key_d   = in_i.key_byte;
        idx_d   = 2'd0;
        done_d  = (in_i.key_byte == KEY_ENTER);
        wfull_d = full;
        if (in_i.key_byte == KEY_BACKSPACE) begin
          if (!empty) begin
            held_d = held_q - 1'b1;
          end
        end else if (!full) begin
          ram_we = 1'b1;
          held_d = held_q + 1'b1;
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_i.action == ACT_READ) ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_EMIT: begin
        if (last_res) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign fill_ext = {{FILL_W{1'b0}}, held_q};

  // Outputs
  always_comb begin
    busy         = 1'b1;
    res_strobe_o = 1'b0;
    res_o        = '0;
    res_o.fill_level = fill_ext[FILL_W-1:0];
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_READ: begin
        res_strobe_o    = 1'b1;
        res_o.read_byte = hit_q ? rdata : 8'd0;
        res_o.last      = 1'b1;
      end
      ST_EMIT: begin
        res_strobe_o     = 1'b1;
        res_o.echo_valid = (echo_len != 2'd0);
        res_o.echo_byte  = (echo_len != 2'd0) ? echo_char : 8'd0;
        res_o.line_done  = done_q;
        res_o.last       = last_res;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      oldest_q  <= '0;
      held_q    <= '0;
      echo_en_q <= 1'b1;
    end else begin
      state_q   <= state_d;
      oldest_q  <= oldest_d;
      held_q    <= held_d;
      echo_en_q <= echo_en_d;
    end
  end

  // Transaction payload registers
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    idx_q   <= idx_d;
    done_q  <= done_d;
    hit_q   <= hit_d;
    wfull_q <= wfull_d;
  end

endmodule

>>> rtl/kblb_checker.sv
// ----------------------------------------------------------------------------
// kblb_checker
// Port-level checks of the line buffer's command and result timing.
// ----------------------------------------------------------------------------
module kblb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                res_strobe_o,
  input kblb_pkg::kblb_out_t res_o
);
  import kblb_pkg::*;

  // An accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // Results appear only inside a transaction
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> busy)
    else $error("result strobe while idle");

  // The final result frees the command channel
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last) |=> !busy)
    else $error("busy held after final result");

  // Echo bytes of one transaction come back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.last) |=> res_strobe_o)
    else $error("gap inside echo sequence");

  // A result without echo is always the only one
  a_no_echo_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.echo_valid) |-> res_o.last)
    else $error("non-echo result not marked last");

endmodule

bind keyboard_line_buffer_with_echo_core kblb_checker u_kblb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);
